// ===== rtl/shct_pkg.sv =====
package shct_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int MAX_SET_BITS = 10;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int MAX_WAYS     = 8;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int FILL_W       = $clog2(MAX_WAYS + 1);
    localparam int COUNT_BITS   = 32;
    localparam int ORDER_W      = MAX_WAYS * WAY_W;
    localparam int META_W       = FILL_W + ORDER_W;
    localparam int TAG_ROW_W    = MAX_WAYS * ADDR_BITS;

    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU = 4'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 is_write;
    } in_t;

    typedef struct packed {
        logic                  hit;
        logic                  mem_read;
        logic                  mem_write;
        logic [COUNT_BITS-1:0] read_total;
        logic [COUNT_BITS-1:0] write_total;
        logic [COUNT_BITS-1:0] hit_total;
        logic [COUNT_BITS-1:0] miss_total;
    } out_t;

    typedef struct packed {
        logic                 hit;
        logic [TAG_ROW_W-1:0] tag_row;
        logic [META_W-1:0]    meta;
    } upd_t;

endpackage

// ===== rtl/set_assoc_cache_hit_tracker_unit.sv =====
// Set-associative cache tag tracker, FIFO or LRU replacement.
// Input channel s_valid/s_ready/s_data carries one access (address, is_write);
// result channel m_valid/m_ready/m_data returns one transaction per access with
// hit, mem_read, mem_write and the four running 32-bit counters (they wrap).
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, index 0 offset_bits,
// 1 set_bits, 2 ways, 3 replace_lru; other indexes ignored. Write only while
// idle. cfg_ready is always high.
// Each access first reads its set from the tag and order memories, then
// compares and writes back the same set, loading the output register with
// the result; the next access is taken only once the write-back is done.
// Reset, and any write of offset_bits, set_bits or ways, starts a clearing pass
// over all 1024 sets of the fill/order memory; s_ready is low meanwhile.
// Counters and replace_lru are kept across geometry writes.
// If m_ready is low, the result waits in the output register and the pending
// write-back holds until the output register frees up.
module set_assoc_cache_hit_tracker_unit import shct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                  state_reg, state_next;
    logic [4:0]            offset_bits_reg;
    logic [3:0]            set_bits_reg;
    logic [3:0]            ways_reg;
    logic                  lru_reg;
    logic                  clr_active_reg;
    logic [SET_W-1:0]      clr_addr_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic                  wr_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg, wr_cnt_reg, hit_cnt_reg, miss_cnt_reg;
    logic [COUNT_BITS-1:0] rd_cnt_next, wr_cnt_next, hit_cnt_next, miss_cnt_next;
    out_t                  out_reg;
    logic                  out_valid_reg;

    logic                  in_acc, cfg_acc, geo_wr, commit;
    logic [3:0]            sb;
    logic [FILL_W-1:0]     nw;
    logic [5:0]            tag_shift;
    logic [ADDR_BITS-1:0]  above;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;
    logic [ADDR_BITS-1:0]  tag_in;
    logic [TAG_ROW_W-1:0]  tag_rdata;
    logic [META_W-1:0]     meta_rdata;
    logic                  meta_we;
    logic [SET_W-1:0]      meta_waddr;
    logic [META_W-1:0]     meta_wdata;
    upd_t                  upd;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;
    assign geo_wr    = cfg_acc && (cfg_index == CFG_OFFSET_BITS || cfg_index == CFG_SET_BITS
                                   || cfg_index == CFG_WAYS);
    assign s_ready   = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_acc    = s_valid && s_ready;
    assign commit    = (state_reg == ST_LOOK) && (!out_valid_reg || m_ready);

    assign sb        = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
    assign nw        = (ways_reg == '0) ? FILL_W'(1)
                     : ((ways_reg > 4'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : ways_reg);
    assign tag_shift = {1'b0, offset_bits_reg} + {2'b00, sb};
    assign above     = s_data.address >> offset_bits_reg;
    assign set_mask  = ~({SET_W{1'b1}} << sb);
    assign set_in    = above[SET_W-1:0] & set_mask;
    assign tag_in    = s_data.address >> tag_shift;

    assign meta_we    = clr_active_reg || commit;
    assign meta_waddr = clr_active_reg ? clr_addr_reg : set_reg;
    assign meta_wdata = clr_active_reg ? '0 : upd.meta;

    shct_ram #(.WIDTH(TAG_ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (upd.tag_row),
        .re    (in_acc),
        .raddr (set_in),
        .rdata (tag_rdata)
    );

    shct_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (in_acc),
        .raddr (set_in),
        .rdata (meta_rdata)
    );

    shct_update u_update (
        .tag      (tag_reg),
        .num_ways (nw),
        .lru      (lru_reg),
        .tag_row  (tag_rdata),
        .meta     (meta_rdata),
        .upd      (upd)
    );

    always_comb begin
        state_next = state_reg;
        if (in_acc) begin
            state_next = ST_LOOK;
        end else if (commit) begin
            state_next = ST_IDLE;
        end
        rd_cnt_next   = rd_cnt_reg   + COUNT_BITS'(!upd.hit);
        miss_cnt_next = miss_cnt_reg + COUNT_BITS'(!upd.hit);
        hit_cnt_next  = hit_cnt_reg  + COUNT_BITS'(upd.hit);
        wr_cnt_next   = wr_cnt_reg   + COUNT_BITS'(wr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            offset_bits_reg <= '0;
            set_bits_reg    <= '0;
            ways_reg        <= 4'd1;
            lru_reg         <= 1'b0;
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            rd_cnt_reg      <= '0;
            wr_cnt_reg      <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_acc) begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[4:0];
                    CFG_SET_BITS:    set_bits_reg    <= cfg_data[3:0];
                    CFG_WAYS:        ways_reg        <= cfg_data[3:0];
                    CFG_REPLACE_LRU: lru_reg         <= cfg_data[0];
                    default: ;
                endcase
            end
            if (geo_wr) begin
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end else if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {SET_W{1'b1}}) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (commit) begin
                rd_cnt_reg    <= rd_cnt_next;
                wr_cnt_reg    <= wr_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            wr_reg  <= s_data.is_write;
        end
        if (commit) begin
            out_reg.hit         <= upd.hit;
            out_reg.mem_read    <= !upd.hit;
            out_reg.mem_write   <= wr_reg;
            out_reg.read_total  <= rd_cnt_next;
            out_reg.write_total <= wr_cnt_next;
            out_reg.hit_total   <= hit_cnt_next;
            out_reg.miss_total  <= miss_cnt_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/shct_ram.sv =====
module shct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/shct_update.sv =====
module shct_update import shct_pkg::*; (
    input  logic [ADDR_BITS-1:0] tag,
    input  logic [FILL_W-1:0]    num_ways,
    input  logic                 lru,
    input  logic [TAG_ROW_W-1:0] tag_row,
    input  logic [META_W-1:0]    meta,
    output upd_t                 upd
);

    logic [ADDR_BITS-1:0] tags [MAX_WAYS];
    logic [WAY_W-1:0]     ord [MAX_WAYS];
    logic [WAY_W-1:0]     ord_new [MAX_WAYS];
    logic [FILL_W-1:0]    fill_raw;
    logic [FILL_W-1:0]    fill;
    logic [FILL_W-1:0]    pos;
    logic                 hit;
    logic                 shift_en;
    logic [WAY_W-1:0]     moved;
    logic [TAG_ROW_W-1:0] row_new;
    logic [FILL_W-1:0]    fill_new;
    logic [ORDER_W-1:0]   ord_flat;

    always_comb begin
        fill_raw = meta[META_W-1:ORDER_W];
        fill     = (fill_raw > num_ways) ? num_ways : fill_raw;
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i] = tag_row[i*ADDR_BITS +: ADDR_BITS];
            ord[i]  = meta[i*WAY_W +: WAY_W];
        end

        // first match in age order
        hit = 1'b0;
        pos = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (FILL_W'(i) < fill && tags[ord[i]] == tag) begin
                hit = 1'b1;
                pos = FILL_W'(i);
            end
        end

        row_new  = tag_row;
        fill_new = fill_raw;
        shift_en = 1'b0;
        if (hit) begin
            shift_en = lru;
        end else if (fill < num_ways) begin
            row_new[fill[WAY_W-1:0]*ADDR_BITS +: ADDR_BITS] = tag;
            fill_new = fill + 1'b1;
        end else begin
            row_new[ord[0]*ADDR_BITS +: ADDR_BITS] = tag;
            shift_en = 1'b1;
            pos      = '0;
        end

        // move way at age position pos to the youngest slot
        moved = ord[pos[WAY_W-1:0]];
        for (int i = 0; i < MAX_WAYS; i++) begin
            ord_new[i] = ord[i];
            if (shift_en && FILL_W'(i) >= pos) begin
                if (FILL_W'(i + 1) < fill) begin
                    ord_new[i] = ord[(i + 1) % MAX_WAYS];
                end else if (FILL_W'(i + 1) == fill) begin
                    ord_new[i] = moved;
                end
            end
        end
        if (!hit && fill < num_ways) begin
            ord_new[fill[WAY_W-1:0]] = fill[WAY_W-1:0];
        end

        for (int i = 0; i < MAX_WAYS; i++) begin
            ord_flat[i*WAY_W +: WAY_W] = ord_new[i];
        end

        upd.hit     = hit;
        upd.tag_row = row_new;
        upd.meta    = {fill_new, ord_flat};
    end

endmodule

// ===== tb/sv/set_assoc_cache_hit_tracker_unit_chk.sv =====
`timescale 1ns / 100ps

module set_assoc_cache_hit_tracker_unit_chk import shct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    err_count,
    output int                    pending_results
);

    logic [ADDR_BITS-1:0] tags [NUM_SETS][MAX_WAYS];
    logic [FILL_W-1:0]    fill [NUM_SETS];
    logic [WAY_W-1:0]     age  [NUM_SETS][MAX_WAYS];
    logic [COUNT_BITS-1:0] rd_cnt, wr_cnt, hit_cnt, miss_cnt;
    logic [4:0] off_bits;
    logic [3:0] set_bits_r, ways_r;
    logic       lru;
    out_t result_q [$];

    assign pending_results = result_q.size();

    // age[set][0] is the oldest way
    function automatic void promote(int s, int pos, int n);
        logic [WAY_W-1:0] w;
        w = age[s][pos];
        for (int i = pos; i + 1 < n; i++) age[s][i] = age[s][i+1];
        age[s][n-1] = w;
    endfunction

    function automatic out_t lookup_access(in_t a);
        out_t r;
        int sb, nw, ob, ts, s, f;
        logic [ADDR_BITS-1:0] above, tag;
        bit found;
        sb = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
        nw = (ways_r == 0) ? 1 : ((ways_r > MAX_WAYS) ? MAX_WAYS : ways_r);
        ob = off_bits;
        ts = ob + sb;
        above = (ob >= 64) ? '0 : (a.address >> ob);
        s = int'(above & ((48'd1 << sb) - 1));
        tag = (ts >= 64) ? '0 : (a.address >> ts);
        f = (fill[s] > nw) ? nw : fill[s];
        found = 0;
        for (int i = 0; i < f; i++) begin
            if (tags[s][age[s][i]] == tag) begin
                found = 1;
                if (lru) promote(s, i, f);
                break;
            end
        end
        if (found) begin
            hit_cnt++;
        end else begin
            if (f < nw) begin
                tags[s][f] = tag;
                age[s][f] = f[WAY_W-1:0];
                fill[s] = FILL_W'(f + 1);
            end else begin
                tags[s][age[s][0]] = tag;
                promote(s, 0, f);
            end
            miss_cnt++;
            rd_cnt++;
        end
        if (a.is_write) wr_cnt++;
        r.hit = found;
        r.mem_read = !found;
        r.mem_write = a.is_write;
        r.read_total = rd_cnt;
        r.write_total = wr_cnt;
        r.hit_total = hit_cnt;
        r.miss_total = miss_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SETS; i++) fill[i] = '0;
            rd_cnt = '0; wr_cnt = '0; hit_cnt = '0; miss_cnt = '0;
            off_bits = '0; set_bits_r = '0; ways_r = 4'd1; lru = 0;
            result_q.delete();
            err_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OFFSET_BITS: off_bits = cfg_data[4:0];
                    CFG_SET_BITS: set_bits_r = cfg_data[3:0];
                    CFG_WAYS: ways_r = cfg_data[3:0];
                    CFG_REPLACE_LRU: lru = cfg_data[0];
                    default: ;
                endcase
                if (cfg_index == CFG_OFFSET_BITS || cfg_index == CFG_SET_BITS ||
                    cfg_index == CFG_WAYS)
                    for (int i = 0; i < NUM_SETS; i++) fill[i] = '0;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    err_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_data !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, m_data);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) result_q.push_back(lookup_access(s_data));
        end
    end

endmodule

// ===== tb/sv/set_assoc_cache_hit_tracker_unit_tb.sv =====
`timescale 1ns / 100ps

module set_assoc_cache_hit_tracker_unit_tb import shct_pkg::*; ();

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_t  s_data;
    out_t m_data;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int err_count, pending_results;
    int idle_cycles;
    bit hold_off;

    set_assoc_cache_hit_tracker_unit i_dut (.*);

    set_assoc_cache_hit_tracker_unit_chk i_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stalls; hold_off forces one long stretch
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            n = gap_len();
            if (n == 0 || $urandom_range(0, 3) == 0) m_ready <= 1;
            else begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
                m_ready <= 1;
            end
        end
    end

    // s_valid stays high after a transaction so the next one can follow at once
    task automatic send_access(logic [ADDR_BITS-1:0] a, logic w, bit no_gap);
        int n;
        n = no_gap ? 0 : gap_len();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data.address <= a;
        s_data.is_write <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_valid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic set_geometry(int ob, int sb, int nw, int l);
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS, nw);
        write_reg(CFG_REPLACE_LRU, l);
    endtask

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        return ADDR_BITS'({$urandom(), $urandom()});
    endfunction

    // addresses from a small pool so sets fill up and tags repeat
    task automatic random_phase(int count, int ob, int sb);
        logic [ADDR_BITS-1:0] pool [12];
        logic [ADDR_BITS-1:0] a;
        for (int i = 0; i < 12; i++) pool[i] = rand_addr();
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                a = pool[$urandom_range(0, 11)];
                a = a ^ ADDR_BITS'($urandom_range(0, (1 << (ob > 4 ? 4 : ob)) - 1));
                if ($urandom_range(0, 1)) a[ADDR_BITS-1 -: 4] = 4'($urandom_range(0, 1));
            end else begin
                a = rand_addr();
            end
            send_access(a, 1'($urandom_range(0, 1)), 0);
        end
    endtask

    initial begin
        s_valid = 0; s_data = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        hold_off = 0;
        idle_cycles = 0;
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // directed: defaults, extremes, hit and eviction paths
        send_access('0, 0, 0);
        send_access('0, 1, 0);
        send_access({ADDR_BITS{1'b1}}, 1, 0);
        send_access({ADDR_BITS{1'b1}}, 0, 0);
        set_geometry(4, 2, 2, 0);
        send_access(48'h100, 0, 0);
        send_access(48'h200, 0, 0);
        send_access(48'h100, 1, 0);
        send_access(48'h300, 0, 0);
        send_access(48'h100, 0, 0);
        write_reg(CFG_REPLACE_LRU, 1);
        send_access(48'h400, 0, 0);
        send_access(48'h500, 0, 0);
        send_access(48'h400, 1, 0);
        send_access(48'h600, 0, 0);
        send_access(48'h400, 0, 0);
        set_geometry(31, 15, 15, 1);
        send_access({ADDR_BITS{1'b1}}, 0, 0);
        send_access(48'h5555_5555_5555, 1, 0);
        send_access({ADDR_BITS{1'b1}}, 1, 0);
        set_geometry(20, 10, 0, 0);
        send_access(48'hABCD_EF12_3456, 0, 0);
        send_access(48'hABCD_EF12_3456, 0, 0);
        write_reg(4'd9, 32'hFFFF_FFFF);
        write_reg(CFG_WAYS, 8);
        send_access(48'h8000_0000_0000, 1, 0);

        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        for (int i = 0; i < 20; i++) send_access(rand_addr(), i[0], 1);

        for (int ph = 0; ph < 8; ph++) begin
            int ob, sb;
            ob = (ph == 0) ? 0 : (ph == 7 ? 20 : $urandom_range(0, 20));
            sb = (ph == 0) ? 0 : (ph == 7 ? 10 : $urandom_range(0, 3));
            set_geometry(ob, sb, (ph == 0) ? 1 : $urandom_range(1, 8), ph % 2);
            random_phase(160, ob, sb);
        end

        s_valid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
